// ===== rtl/core/cmf_pkg.sv =====
// Shared types, constants and register codes of the cross median filter.
`default_nettype none

package cmf_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_PIXEL_BITS = 32;

	localparam int WORD_BITS    = 32;
	localparam int CFG_BITS     = 11;
	localparam int POS_BITS     = 10;
	localparam int ADDR_BITS    = 3;
	localparam int QUEUE_DEPTH  = 4;
	localparam int CROSS_POINTS = 5;
	localparam int MEDIAN_RANK  = CROSS_POINTS / 2;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd480;

	typedef enum logic {
		CMD_PIXEL,
		CMD_DRAIN
	} command_t;

	typedef enum logic {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} reg_index_t;

	typedef struct packed {
		command_t              command;
		logic [WORD_BITS-1:0]  pixel_value;
	} pix_item_t;

	typedef struct packed {
		logic [WORD_BITS-1:0]  filtered_value;
		logic [POS_BITS-1:0]   out_column;
		logic [POS_BITS-1:0]   out_row;
		logic                  last_of_frame;
	} res_item_t;

	// One classified request handed from the front to the back.
	typedef struct packed {
		logic                  emit;
		logic                  write_prev;
		logic                  has_up;
		logic                  has_down;
		logic                  has_left;
		logic                  has_right;
		logic                  last_of_frame;
		logic [POS_BITS-1:0]   out_column;
		logic [POS_BITS-1:0]   out_row;
		logic [WORD_BITS-1:0]  pixel;
	} task_t;

endpackage

`default_nettype wire

// ===== rtl/core/cmf_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module cmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]          wdata,
	input  wire logic                      re,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr_b,
	output logic      [WIDTH-1:0]          rdata_a,
	output logic      [WIDTH-1:0]          rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cmf_front.sv =====
// Front end: accepts pixels and drains, tracks position, classifies requests.
`default_nettype none

module cmf_front #(
	parameter int MAX_WIDTH  = cmf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cmf_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pix_valid,
	output logic                                  pix_stall,
	input  wire cmf_pkg::pix_item_t               pix_data,
	input  wire logic [cmf_pkg::CFG_BITS-1:0]     image_width,
	input  wire logic [cmf_pkg::CFG_BITS-1:0]     image_height,
	input  wire logic                             queue_full,
	output logic                                  push,
	output cmf_pkg::task_t                        push_task,
	output logic [$clog2(MAX_WIDTH)-1:0]          push_addr
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WCMP = (CW + 1 > cmf_pkg::CFG_BITS) ? CW + 1 : cmf_pkg::CFG_BITS;
	localparam int HCMP = (RW + 1 > cmf_pkg::CFG_BITS) ? RW + 1 : cmf_pkg::CFG_BITS;
	localparam int PW   = cmf_pkg::POS_BITS;

	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   drain_q;
	logic            draining_q;

	logic [WCMP-1:0] width_eff;
	logic [HCMP-1:0] height_eff;
	logic [WCMP-1:0] width_raw;
	logic [HCMP-1:0] height_raw;
	logic            accept;
	logic            is_pixel;
	logic [CW-1:0]   cur_col;
	logic [RW-1:0]   cur_row;
	logic [WCMP-1:0] col_inc;
	logic [WCMP-1:0] drain_inc;
	logic [HCMP-1:0] row_inc;
	logic            row_end;
	logic            frame_end;
	logic            drain_end;
	logic [CW+PW-1:0] col_wide;
	logic [RW+PW-1:0] row_wide;

	assign pix_stall = queue_full;
	assign accept    = pix_valid && !pix_stall;
	assign is_pixel  = (pix_data.command == cmf_pkg::CMD_PIXEL);

	// Clamp the frame size into the supported range.
	always_comb begin
		width_raw  = WCMP'(image_width);
		height_raw = HCMP'(image_height);
		if (width_raw < WCMP'(2)) begin
			width_eff = WCMP'(2);
		end else if (width_raw > WCMP'(MAX_WIDTH)) begin
			width_eff = WCMP'(MAX_WIDTH);
		end else begin
			width_eff = width_raw;
		end
		if (height_raw < HCMP'(1)) begin
			height_eff = HCMP'(1);
		end else if (height_raw > HCMP'(MAX_HEIGHT)) begin
			height_eff = HCMP'(MAX_HEIGHT);
		end else begin
			height_eff = height_raw;
		end
	end

	assign col_inc   = WCMP'(col_q) + WCMP'(1);
	assign drain_inc = WCMP'(drain_q) + WCMP'(1);
	assign row_inc   = HCMP'(row_q) + HCMP'(1);
	assign row_end   = (col_inc >= width_eff);
	assign frame_end = (row_inc >= height_eff);
	assign drain_end = (drain_inc >= width_eff);

	always_comb begin
		push_task            = '0;
		push                 = 1'b0;
		cur_col              = col_q;
		cur_row              = row_q - RW'(1);
		if (is_pixel) begin
			push                    = accept && !draining_q;
			push_task.emit          = (row_q != '0);
			push_task.write_prev    = 1'b1;
			push_task.has_up        = (row_q > RW'(1));
			push_task.has_down      = 1'b1;
			push_task.last_of_frame = 1'b0;
		end else begin
			cur_col                 = drain_q;
			cur_row                 = RW'(height_eff - HCMP'(1));
			push                    = accept && draining_q;
			push_task.emit          = 1'b1;
			push_task.write_prev    = 1'b0;
			push_task.has_up        = (height_eff > HCMP'(1));
			push_task.has_down      = 1'b0;
			push_task.last_of_frame = drain_end;
		end
		push_task.has_left  = (cur_col != '0);
		push_task.has_right = ((WCMP'(cur_col) + WCMP'(1)) < width_eff);
		col_wide            = (CW+PW)'(cur_col);
		row_wide            = (RW+PW)'(cur_row);
		push_task.out_column = col_wide[PW-1:0];
		push_task.out_row    = row_wide[PW-1:0];
		push_task.pixel      = pix_data.pixel_value;
		push_addr            = cur_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
		end else if (push) begin
			if (is_pixel) begin
				if (row_end) begin
					col_q <= '0;
					if (frame_end) begin
						row_q      <= '0;
						draining_q <= 1'b1;
						drain_q    <= '0;
					end else begin
						row_q <= row_inc[RW-1:0];
					end
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end else begin
				if (drain_end) begin
					draining_q <= 1'b0;
					drain_q    <= '0;
				end else begin
					drain_q <= drain_inc[CW-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cmf_queue.sv =====
// Small register queue between the front and the back.
`default_nettype none

module cmf_queue #(
	parameter int WIDTH = 64,
	parameter int DEPTH = cmf_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] dout,
	output logic                  full,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cmf_back.sv =====
// Back end: row stores, neighbor fetch with bypass, five-point median, result register.
`default_nettype none

module cmf_back #(
	parameter int MAX_WIDTH  = cmf_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = cmf_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         task_valid,
	input  wire cmf_pkg::task_t               task_data,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] task_addr,
	output logic                              task_pop,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output cmf_pkg::res_item_t                res_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int NP = cmf_pkg::CROSS_POINTS;
	localparam int RK = $clog2(NP);

	logic                  adv;
	logic                  wr_s1;

	logic [PIXEL_BITS-1:0] older_a;
	logic [PIXEL_BITS-1:0] older_b;
	logic [PIXEL_BITS-1:0] prev_a;
	logic [PIXEL_BITS-1:0] prev_b;

	logic                  valid_s1;
	cmf_pkg::task_t        task_s1;
	logic [CW-1:0]         addr_s1;

	// most recent write to each store, for the read issued at the same edge
	logic [CW-1:0]         lwo_addr_q;
	logic [PIXEL_BITS-1:0] lwo_data_q;
	logic                  lwo_vld_q;
	logic [CW-1:0]         lwp_addr_q;
	logic [PIXEL_BITS-1:0] lwp_data_q;
	logic                  lwp_vld_q;

	logic [PIXEL_BITS-1:0] centre;
	logic [PIXEL_BITS-1:0] up_v;
	logic [PIXEL_BITS-1:0] down_v;
	logic [PIXEL_BITS-1:0] left_v;
	logic [PIXEL_BITS-1:0] right_v;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [CW-1:0]         addr_left_s1;
	logic [CW-1:0]         addr_right_s1;

	logic                  valid_s2;
	logic [PIXEL_BITS-1:0] vals_s2 [NP];
	logic [cmf_pkg::POS_BITS-1:0] col_s2;
	logic [cmf_pkg::POS_BITS-1:0] row_s2;
	logic                  last_s2;

	logic [PIXEL_BITS-1:0] median;
	logic                  res_valid_q;
	cmf_pkg::res_item_t    res_q;

	assign adv      = !res_valid_q || !res_stall;
	assign task_pop = adv && task_valid;
	assign wr_s1    = adv && valid_s1;

	assign pix_s1        = task_s1.pixel[PIXEL_BITS-1:0];
	assign addr_left_s1  = addr_s1 - CW'(1);
	assign addr_right_s1 = addr_s1 + CW'(1);

	logic [PIXEL_BITS-1:0] older_rd_a;
	logic [PIXEL_BITS-1:0] older_rd_b;
	logic [PIXEL_BITS-1:0] prev_rd_a;
	logic [PIXEL_BITS-1:0] prev_rd_b;

	cmf_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_older_ram (
		.clk     (clk),
		.we      (wr_s1),
		.waddr   (addr_s1),
		.wdata   (centre),
		.re      (task_pop),
		.raddr_a (task_addr),
		.raddr_b (task_addr - CW'(1)),
		.rdata_a (older_rd_a),
		.rdata_b (older_rd_b)
	);

	cmf_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_prev_ram (
		.clk     (clk),
		.we      (wr_s1 && task_s1.write_prev),
		.waddr   (addr_s1),
		.wdata   (pix_s1),
		.re      (task_pop),
		.raddr_a (task_addr),
		.raddr_b (task_addr + CW'(1)),
		.rdata_a (prev_rd_a),
		.rdata_b (prev_rd_b)
	);

	// Replace the read data with the write that landed at the read edge.
	always_comb begin
		older_a = (lwo_vld_q && lwo_addr_q == addr_s1)       ? lwo_data_q : older_rd_a;
		older_b = (lwo_vld_q && lwo_addr_q == addr_left_s1)  ? lwo_data_q : older_rd_b;
		prev_a  = (lwp_vld_q && lwp_addr_q == addr_s1)       ? lwp_data_q : prev_rd_a;
		prev_b  = (lwp_vld_q && lwp_addr_q == addr_right_s1) ? lwp_data_q : prev_rd_b;
		centre  = prev_a;
		up_v    = task_s1.has_up    ? older_a : centre;
		down_v  = task_s1.has_down  ? pix_s1  : centre;
		left_v  = task_s1.has_left  ? older_b : centre;
		right_v = task_s1.has_right ? prev_b  : centre;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			lwo_vld_q <= 1'b0;
			lwp_vld_q <= 1'b0;
			valid_s2  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1    <= task_pop;
				valid_s2    <= valid_s1 && task_s1.emit;
				res_valid_q <= valid_s2;
			end
			if (wr_s1) begin
				lwo_vld_q <= 1'b1;
				if (task_s1.write_prev) begin
					lwp_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (task_pop) begin
			task_s1 <= task_data;
			addr_s1 <= task_addr;
		end
		if (wr_s1) begin
			lwo_addr_q <= addr_s1;
			lwo_data_q <= centre;
			if (task_s1.write_prev) begin
				lwp_addr_q <= addr_s1;
				lwp_data_q <= pix_s1;
			end
			vals_s2[0] <= centre;
			vals_s2[1] <= up_v;
			vals_s2[2] <= down_v;
			vals_s2[3] <= left_v;
			vals_s2[4] <= right_v;
			col_s2     <= task_s1.out_column;
			row_s2     <= task_s1.out_row;
			last_s2    <= task_s1.last_of_frame;
		end
		if (adv && valid_s2) begin
			res_q.filtered_value <= cmf_pkg::WORD_BITS'(median);
			res_q.out_column     <= col_s2;
			res_q.out_row        <= row_s2;
			res_q.last_of_frame  <= last_s2;
		end
	end

	// Rank each value with ties broken by position; take the middle rank.
	always_comb begin
		logic [RK-1:0] rank;
		median = vals_s2[0];
		for (int i = 0; i < NP; i++) begin
			rank = '0;
			for (int j = 0; j < NP; j++) begin
				if (j != i) begin
					if (vals_s2[j] < vals_s2[i] || (vals_s2[j] == vals_s2[i] && j < i)) begin
						rank = rank + RK'(1);
					end
				end
			end
			if (rank == RK'(cmf_pkg::MEDIAN_RANK)) begin
				median = vals_s2[i];
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/cross_median_filter.sv =====
// Top level of the cross median filter: register port, front, queue and back.
`default_nettype none

// Five-point cross median over a raster-order pixel stream. The block takes one
// request per clock while pix_stall is low: command 0 carries the next pixel,
// command 1 drains one output of the last row once the frame's final pixel is in.
// Results for row r come out while row r+1 streams in; the final row needs one
// drain request per column of the clamped image_width. Pixels and drains that have
// nothing to do are accepted and dropped. Sustained rate is one request per cycle
// while results are not stalled, set by the single write port of each of the two
// row stores (MAX_WIDTH words each); a four-entry queue lets the input keep
// flowing until it fills while results are stalled. Row stores are not cleared
// after reset. Write image_width and image_height only while the block is idle.
module cross_median_filter #(
	parameter int MAX_WIDTH  = cmf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cmf_pkg::DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = cmf_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pix_valid,
	output logic                                   pix_stall,
	input  wire cmf_pkg::pix_item_t                pix_data,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output cmf_pkg::res_item_t                     res_data,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [cmf_pkg::ADDR_BITS-1:0]     paddr,
	input  wire logic [cmf_pkg::WORD_BITS-1:0]     pwdata,
	output logic      [cmf_pkg::WORD_BITS-1:0]     prdata,
	output logic                                   pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int TW = $bits(cmf_pkg::task_t);
	localparam int QW = TW + CW;

	logic [cmf_pkg::CFG_BITS-1:0] width_q;
	logic [cmf_pkg::CFG_BITS-1:0] height_q;
	cmf_pkg::reg_index_t          reg_sel;
	logic                         reg_write;

	logic                         push;
	cmf_pkg::task_t               push_task;
	logic [CW-1:0]                push_addr;
	logic                         q_full;
	logic                         q_empty;
	logic                         q_pop;
	logic [QW-1:0]                q_dout;
	cmf_pkg::task_t               head_task;
	logic [CW-1:0]                head_addr;

	assign pready    = 1'b1;
	assign reg_sel   = cmf_pkg::reg_index_t'(paddr[2]);
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cmf_pkg::WIDTH_RESET;
			height_q <= cmf_pkg::HEIGHT_RESET;
		end else if (reg_write) begin
			unique case (reg_sel)
				cmf_pkg::REG_IMAGE_WIDTH: begin
					width_q <= pwdata[cmf_pkg::CFG_BITS-1:0];
				end
				cmf_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= pwdata[cmf_pkg::CFG_BITS-1:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			cmf_pkg::REG_IMAGE_WIDTH: begin
				prdata = cmf_pkg::WORD_BITS'(width_q);
			end
			cmf_pkg::REG_IMAGE_HEIGHT: begin
				prdata = cmf_pkg::WORD_BITS'(height_q);
			end
		endcase
	end

	cmf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.pix_data     (pix_data),
		.image_width  (width_q),
		.image_height (height_q),
		.queue_full   (q_full),
		.push         (push),
		.push_task    (push_task),
		.push_addr    (push_addr)
	);

	cmf_queue #(
		.WIDTH (QW),
		.DEPTH (cmf_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({push_task, push_addr}),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign head_task = cmf_pkg::task_t'(q_dout[QW-1:CW]);
	assign head_addr = q_dout[CW-1:0];

	cmf_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_valid (!q_empty),
		.task_data  (head_task),
		.task_addr  (head_addr),
		.task_pop   (q_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("request pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("request popped from an empty queue");

	a_full_empty_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue reports full and empty at once");

	a_push_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (pix_valid && !pix_stall))
		else $error("request queued without an accepted input");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the cross median filter: stream, register port and checker.
module tb;

	localparam int MAX_COLS      = cmf_pkg::DEF_MAX_WIDTH;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int FLUSH_WIDTH   = 128;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 300000;

	typedef enum logic [1:0] {
		STEP_ITEM,
		STEP_SET_WIDTH,
		STEP_SET_HEIGHT
	} step_kind_t;

	typedef struct packed {
		step_kind_t                    kind;
		cmf_pkg::command_t             command;
		logic [cmf_pkg::WORD_BITS-1:0] value;
		logic                          typed;
		cmf_pkg::res_item_t            want;
	} plan_step_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          pix_valid = 1'b0;
	logic                          pix_stall;
	cmf_pkg::pix_item_t            pix_data  = '0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	cmf_pkg::res_item_t            res_data;
	logic                          psel      = 1'b0;
	logic                          penable   = 1'b0;
	logic                          pwrite    = 1'b0;
	logic [cmf_pkg::ADDR_BITS-1:0] paddr     = '0;
	logic [cmf_pkg::WORD_BITS-1:0] pwdata    = '0;
	logic [cmf_pkg::WORD_BITS-1:0] prdata;
	logic                          pready;

	// Mirror of the filter: two line stores, raster position and register copies.
	logic [cmf_pkg::WORD_BITS-1:0] upper_line [MAX_COLS];
	logic [cmf_pkg::WORD_BITS-1:0] older_line [MAX_COLS];
	int unsigned                   col_pos   = 0;
	int unsigned                   row_pos   = 0;
	int unsigned                   drain_pos = 0;
	bit                            flushing  = 1'b0;
	logic [cmf_pkg::CFG_BITS-1:0]  width_reg  = cmf_pkg::WIDTH_RESET;
	logic [cmf_pkg::CFG_BITS-1:0]  height_reg = cmf_pkg::HEIGHT_RESET;

	cmf_pkg::res_item_t pending_medians [$];
	int unsigned error_count     = 0;
	int unsigned medians_checked = 0;
	int unsigned frames_done     = 0;
	int unsigned reg_writes      = 0;
	int unsigned cycle_count     = 0;
	bit          quiet           = 1'b0;
	bit          hold_armed      = 1'b0;
	bit          holding         = 1'b0;

	plan_step_t directed_plan [20] = '{
		'{STEP_SET_WIDTH,  cmf_pkg::CMD_PIXEL, 32'd1,         1'b0, '0},
		'{STEP_SET_HEIGHT, cmf_pkg::CMD_PIXEL, 32'd2,         1'b0, '0},
		'{STEP_ITEM,       cmf_pkg::CMD_DRAIN, 32'h1234_5678, 1'b0, '0},
		'{STEP_ITEM,       cmf_pkg::CMD_PIXEL, 32'h0000_0000, 1'b0, '0},
		'{STEP_ITEM,       cmf_pkg::CMD_PIXEL, 32'hFFFF_FFFF, 1'b0, '0},
		'{STEP_ITEM, cmf_pkg::CMD_PIXEL, 32'h8000_0000, 1'b1,
			'{32'h0000_0000, 10'd0, 10'd0, 1'b0}},
		'{STEP_ITEM, cmf_pkg::CMD_PIXEL, 32'h7FFF_FFFF, 1'b1,
			'{32'hFFFF_FFFF, 10'd1, 10'd0, 1'b0}},
		'{STEP_ITEM,       cmf_pkg::CMD_PIXEL, 32'h0000_0005, 1'b0, '0},
		'{STEP_ITEM, cmf_pkg::CMD_DRAIN, 32'h0000_0000, 1'b1,
			'{32'h8000_0000, 10'd0, 10'd1, 1'b0}},
		'{STEP_ITEM, cmf_pkg::CMD_DRAIN, 32'hFFFF_FFFF, 1'b1,
			'{32'h7FFF_FFFF, 10'd1, 10'd1, 1'b1}},
		'{STEP_ITEM,       cmf_pkg::CMD_DRAIN, 32'h0000_0000, 1'b0, '0},
		'{STEP_SET_WIDTH,  cmf_pkg::CMD_PIXEL, 32'd3,         1'b0, '0},
		'{STEP_SET_HEIGHT, cmf_pkg::CMD_PIXEL, 32'd0,         1'b0, '0},
		'{STEP_ITEM,       cmf_pkg::CMD_PIXEL, 32'd9,         1'b0, '0},
		'{STEP_ITEM,       cmf_pkg::CMD_PIXEL, 32'd3,         1'b0, '0},
		'{STEP_ITEM,       cmf_pkg::CMD_PIXEL, 32'd7,         1'b0, '0},
		'{STEP_ITEM,       cmf_pkg::CMD_PIXEL, 32'd1,         1'b0, '0},
		'{STEP_ITEM,       cmf_pkg::CMD_DRAIN, 32'd0,         1'b0, '0},
		'{STEP_ITEM,       cmf_pkg::CMD_DRAIN, 32'd0,         1'b0, '0},
		'{STEP_ITEM,       cmf_pkg::CMD_DRAIN, 32'd0,         1'b0, '0}
	};

	cross_median_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_medians.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(input string what,
			input logic [cmf_pkg::WORD_BITS-1:0] got,
			input logic [cmf_pkg::WORD_BITS-1:0] want);
		$display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
		error_count++;
	endtask

	function automatic int unsigned eff_width();
		if (width_reg < 2) return 2;
		if (width_reg > MAX_COLS) return MAX_COLS;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg < 1) return 1;
		if (height_reg > cmf_pkg::DEF_MAX_HEIGHT) return cmf_pkg::DEF_MAX_HEIGHT;
		return height_reg;
	endfunction

	// Median of the cross around column c of the row held in upper_line; shift that
	// column into older_line afterwards.
	function automatic logic [cmf_pkg::WORD_BITS-1:0] cross_median(input int unsigned c,
			input int unsigned w, input bit up_ok, input bit down_ok,
			input logic [cmf_pkg::WORD_BITS-1:0] below);
		logic [cmf_pkg::WORD_BITS-1:0] v [5];
		logic [cmf_pkg::WORD_BITS-1:0] centre;
		logic [cmf_pkg::WORD_BITS-1:0] t;
		centre = upper_line[c];
		v[0] = centre;
		v[1] = up_ok ? older_line[c] : centre;
		v[2] = down_ok ? below : centre;
		v[3] = (c > 0) ? older_line[c-1] : centre;
		v[4] = (c + 1 < w && c + 1 < MAX_COLS) ? upper_line[c+1] : centre;
		older_line[c] = centre;
		for (int i = 0; i < 5; i++)
			for (int j = i + 1; j < 5; j++)
				if (v[j] < v[i]) begin
					t = v[i];
					v[i] = v[j];
					v[j] = t;
				end
		return v[2];
	endfunction

	task automatic predict_median(input cmf_pkg::pix_item_t req, output bit ignored,
			output bit has_res, output cmf_pkg::res_item_t res);
		int unsigned w;
		int unsigned h;
		w = eff_width();
		h = eff_height();
		ignored = 1'b0;
		has_res = 1'b0;
		res = '0;
		if (req.command == cmf_pkg::CMD_PIXEL) begin
			if (flushing) begin
				ignored = 1'b1;
			end else begin
				if (row_pos > 0) begin
					res.filtered_value = cross_median(col_pos, w, row_pos > 1, 1'b1,
						req.pixel_value);
					res.out_column = cmf_pkg::POS_BITS'(col_pos);
					res.out_row = cmf_pkg::POS_BITS'(row_pos - 1);
					has_res = 1'b1;
				end else begin
					older_line[col_pos] = upper_line[col_pos];
				end
				upper_line[col_pos] = req.pixel_value;
				if (col_pos + 1 >= w) begin
					col_pos = 0;
					if (row_pos + 1 >= h) begin
						row_pos = 0;
						flushing = 1'b1;
						drain_pos = 0;
					end else begin
						row_pos++;
					end
				end else begin
					col_pos++;
				end
			end
		end else if (!flushing) begin
			ignored = 1'b1;
		end else begin
			res.filtered_value = cross_median(drain_pos, w, h > 1, 1'b0, '0);
			res.out_column = cmf_pkg::POS_BITS'(drain_pos);
			res.out_row = cmf_pkg::POS_BITS'(h - 1);
			res.last_of_frame = (drain_pos + 1 >= w);
			has_res = 1'b1;
			if (drain_pos + 1 >= w) begin
				flushing = 1'b0;
				drain_pos = 0;
				frames_done++;
			end else begin
				drain_pos++;
			end
		end
	endtask

	function automatic logic [cmf_pkg::WORD_BITS-1:0] random_pixel();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 30) return $urandom_range(3, 0);
		if (pick < 40) return pick[0] ? '1 : '0;
		return $urandom;
	endfunction

	// Offer one request after a random gap, hold it until accepted, then predict.
	task automatic push_request(input cmf_pkg::pix_item_t req, input bit typed,
			input cmf_pkg::res_item_t want, output bit ignored);
		bit                 has_res;
		cmf_pkg::res_item_t res;
		while (!quiet && $urandom_range(99) < 13) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_data <= req;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		predict_median(req, ignored, has_res, res);
		if (has_res)
			pending_medians.push_back(typed ? want : res);
	endtask

	// Drop valid, wait for every outstanding result and let the pipeline empty.
	task automatic settle();
		pix_valid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_register(input cmf_pkg::reg_index_t idx,
			input logic [cmf_pkg::CFG_BITS-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[cmf_pkg::CFG_BITS-1:0] !== want)
			report_mismatch(idx == cmf_pkg::REG_IMAGE_WIDTH ? "image_width readback" :
				"image_height readback", prdata, cmf_pkg::WORD_BITS'(want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_register(input cmf_pkg::reg_index_t idx,
			input logic [cmf_pkg::CFG_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// upper bits are outside the register and must be dropped
		pwdata <= {(cmf_pkg::WORD_BITS - cmf_pkg::CFG_BITS)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx == cmf_pkg::REG_IMAGE_WIDTH)
			width_reg = value;
		else
			height_reg = value;
		reg_writes++;
		check_register(idx, value);
	endtask

	// One frame of random content with stray requests mixed in; tall frames and a few
	// random points get their size cut down while the frame is in flight.
	task automatic run_frame(input bit force_tall, inout int unsigned items_done);
		bit                 started;
		bit                 ignored;
		int unsigned        pick;
		cmf_pkg::pix_item_t req;
		settle();
		pick = $urandom_range(99);
		set_register(cmf_pkg::REG_IMAGE_WIDTH,
			pick < 8 ? cmf_pkg::CFG_BITS'($urandom_range(1, 0)) :
			pick < 85 ? cmf_pkg::CFG_BITS'($urandom_range(9, 2)) :
			cmf_pkg::CFG_BITS'($urandom_range(48, 10)));
		pick = $urandom_range(99);
		if (force_tall)
			set_register(cmf_pkg::REG_IMAGE_HEIGHT, '1);
		else
			set_register(cmf_pkg::REG_IMAGE_HEIGHT, pick < 5 ? cmf_pkg::CFG_BITS'(0) :
				pick < 90 ? cmf_pkg::CFG_BITS'($urandom_range(5, 1)) :
				cmf_pkg::CFG_BITS'($urandom_range(2047, 1025)));
		started = 1'b0;
		while (!started || col_pos != 0 || row_pos != 0 || flushing) begin
			if (started && ((eff_height() > 8 && row_pos >= 3) ||
					$urandom_range(399) == 0)) begin
				settle();
				set_register(cmf_pkg::REG_IMAGE_HEIGHT,
					cmf_pkg::CFG_BITS'($urandom_range(row_pos + 1, 0)));
				// only shrink: a wider row would read columns never stored this frame
				if ($urandom_range(1) == 1)
					set_register(cmf_pkg::REG_IMAGE_WIDTH,
						cmf_pkg::CFG_BITS'($urandom_range(eff_width(), 0)));
			end
			req.command = (flushing ^ ($urandom_range(19) == 0)) ? cmf_pkg::CMD_DRAIN :
				cmf_pkg::CMD_PIXEL;
			req.pixel_value = random_pixel();
			push_request(req, 1'b0, '0, ignored);
			if (!ignored) begin
				started = 1'b1;
				items_done++;
			end
		end
	endtask

	always @(posedge clk)
		res_stall <= holding || (!quiet && $urandom_range(99) < 13);

	// Long receiver hold-off so the block backs up into its input.
	initial begin
		wait (hold_armed);
		@(posedge clk);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	always @(posedge clk) begin
		cmf_pkg::res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_medians.size() == 0) begin
				report_mismatch("result with nothing pending", res_data.filtered_value, '0);
			end else begin
				want = pending_medians.pop_front();
				medians_checked++;
				if (res_data.filtered_value !== want.filtered_value)
					report_mismatch("filtered_value", res_data.filtered_value,
						want.filtered_value);
				if (res_data.out_column !== want.out_column)
					report_mismatch("out_column", cmf_pkg::WORD_BITS'(res_data.out_column),
						cmf_pkg::WORD_BITS'(want.out_column));
				if (res_data.out_row !== want.out_row)
					report_mismatch("out_row", cmf_pkg::WORD_BITS'(res_data.out_row),
						cmf_pkg::WORD_BITS'(want.out_row));
				if (res_data.last_of_frame !== want.last_of_frame)
					report_mismatch("last_of_frame",
						cmf_pkg::WORD_BITS'(res_data.last_of_frame),
						cmf_pkg::WORD_BITS'(want.last_of_frame));
			end
		end
	end

	initial begin
		int unsigned        random_done;
		bit                 ignored;
		cmf_pkg::pix_item_t req;
		random_done = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_register(cmf_pkg::REG_IMAGE_WIDTH, cmf_pkg::WIDTH_RESET);
		check_register(cmf_pkg::REG_IMAGE_HEIGHT, cmf_pkg::HEIGHT_RESET);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == STEP_ITEM) begin
				req.command = directed_plan[i].command;
				req.pixel_value = directed_plan[i].value;
				push_request(req, directed_plan[i].typed, directed_plan[i].want, ignored);
			end else begin
				settle();
				set_register(directed_plan[i].kind == STEP_SET_WIDTH ?
					cmf_pkg::REG_IMAGE_WIDTH : cmf_pkg::REG_IMAGE_HEIGHT,
					directed_plan[i].value[cmf_pkg::CFG_BITS-1:0]);
			end
		end

		while (random_done < RANDOM_ITEMS)
			run_frame(random_done == 0, random_done);

		// Wide single-row frame, no idling, receiver held off during the flush.
		settle();
		quiet <= 1'b1;
		set_register(cmf_pkg::REG_IMAGE_WIDTH, cmf_pkg::CFG_BITS'(FLUSH_WIDTH));
		set_register(cmf_pkg::REG_IMAGE_HEIGHT, cmf_pkg::CFG_BITS'(1));
		req.command = cmf_pkg::CMD_PIXEL;
		for (int i = 0; i < FLUSH_WIDTH; i++) begin
			req.pixel_value = random_pixel();
			push_request(req, 1'b0, '0, ignored);
		end
		hold_armed <= 1'b1;
		req.command = cmf_pkg::CMD_DRAIN;
		for (int i = 0; i < FLUSH_WIDTH; i++) begin
			req.pixel_value = random_pixel();
			push_request(req, 1'b0, '0, ignored);
		end

		settle();
		$display("ran %0d frames through %0d register writes, clamped sizes and in-frame resizes",
			frames_done, reg_writes);
		$display("checked %0d filtered pixels against the predictor", medians_checked);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
